FILE: hw/rtl/sctbl_pkg.sv
// Shared types, constants and codes for the site counter hash table.
// No dependencies; every other file of the block imports this package.
package sctbl_pkg;

  localparam int TableSize     = 997;
  localparam int SlotW         = $clog2(TableSize);
  localparam int CntW          = $clog2(TableSize + 1);
  localparam int HashMult      = 1777;
  localparam int FillMargin    = 100;
  localparam int FillThr       = TableSize - FillMargin;
  localparam int SectionWeight = 10000;
  localparam int ClientWeight  = 100;

  // Modulo reduction: fold the upper 16 bits twice, then reciprocal multiply.
  localparam int     Pow16Mod   = 65536 % TableSize;
  localparam int     V1W        = 17 + SlotW;
  localparam int     V2W        = ((2 * SlotW + 1 > 16) ? 2 * SlotW + 1 : 16) + 1;
  localparam int     RecipShift = V2W;
  localparam longint Recip      = (64'd1 << RecipShift) / TableSize;
  localparam int     RecipW     = RecipShift - SlotW + 2;
  localparam int     QW         = V2W - SlotW + 1;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgDebugEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectionCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClientCount  = 2'd2;

  localparam logic [1:0] StatCounted  = 2'd0;
  localparam logic [1:0] StatDisabled = 2'd1;
  localparam logic [1:0] StatDropped  = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] line;
    logic [31:0] live;
    logic [31:0] peak;
    logic [47:0] total;
  } row_t;

  typedef struct packed {
    logic start;
    logic emit_off;
    logic load_idx;
    logic rd;
    logic commit;
    logic next_probe;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic enabled;
    logic out_free;
    logic hit;
    logic probe_last;
  } stat_t;

endpackage

FILE: hw/rtl/sctbl_if.sv
// Channel interfaces of the site counter hash table: input, result, config.
// Depends on sctbl_pkg for the config field widths.
interface sctbl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] site_key;
  logic [15:0] site_line;
  logic        func;
  modport source (output valid, site_key, site_line, func, input ready);
  modport sink (input valid, site_key, site_line, func, output ready);
endinterface

interface sctbl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [9:0]         slot;
  logic signed [31:0] live_count;
  logic               new_leak;
  logic               peak_raised;
  logic [9:0]         leak_position;
  modport source (output valid, status, slot, live_count, new_leak, peak_raised,
                  leak_position, input ready);
  modport sink (input valid, status, slot, live_count, new_leak, peak_raised,
                leak_position, output ready);
endinterface

interface sctbl_cfg_if;
  import sctbl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sctbl_ctrl.sv
// Controller of the site counter hash table: clear sweep, hash wait, probe loop.
// Depends on sctbl_pkg for the command and status structs.
module sctbl_ctrl import sctbl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StH1    = 4'd2;
  localparam logic [3:0] StH2    = 4'd3;
  localparam logic [3:0] StH3    = 4'd4;
  localparam logic [3:0] StH4    = 4'd5;
  localparam logic [3:0] StLoad  = 4'd6;
  localparam logic [3:0] StRead  = 4'd7;
  localparam logic [3:0] StCheck = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        // disabled items answer at once and so need a free result register
        in_ready_o = stat_i.enabled || stat_i.out_free;
        if (in_valid_i && in_ready_o) begin
          if (stat_i.enabled) begin
            cmd_o.start = 1'b1;
            state_d     = StH1;
          end else begin
            cmd_o.emit_off = 1'b1;
          end
        end
      end
      StH1:   state_d = StH2;
      StH2:   state_d = StH3;
      StH3:   state_d = StH4;
      StH4:   state_d = StLoad;
      StLoad: begin
        cmd_o.load_idx = 1'b1;
        state_d        = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StCheck;
      end
      StCheck: begin
        // hold until the result register can take the item
        if (stat_i.out_free) begin
          if (stat_i.hit || stat_i.probe_last) begin
            cmd_o.commit = 1'b1;
            state_d      = StIdle;
          end else begin
            cmd_o.next_probe = 1'b1;
            state_d          = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/sctbl_dp.sv
// Datapath of the site counter hash table: config, hash, slot memory, result.
// Depends on sctbl_pkg; driven by sctbl_ctrl through cmd_t and stat_t.
module sctbl_dp import sctbl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         in_key_i,
  input  logic [15:0]         in_line_i,
  input  logic                in_func_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_status_o,
  output logic [9:0]          out_slot_o,
  output logic signed [31:0]  out_live_count_o,
  output logic                out_new_leak_o,
  output logic                out_peak_raised_o,
  output logic [9:0]          out_leak_position_o,
  input  cmd_t                cmd_i,
  output stat_t               stat_o
);

  // configuration
  logic               debug_q;
  logic [9:0]         section_q;
  logic [15:0]        client_q;
  logic signed [31:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debug_q   <= 1'b0;
      section_q <= '0;
      client_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebugEnable:  debug_q   <= cfg_data_i[0];
        CfgSectionCount: section_q <= cfg_data_i[9:0];
        CfgClientCount:  client_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= 32'(SectionWeight) * (32'(section_q) + 32'd1)
             + 32'(ClientWeight) * 32'(client_q);
  end

  // captured item and hash pipeline
  logic [31:0]       key_q;
  logic [15:0]       line_q;
  logic              func_q;
  logic [31:0]       h_q;
  logic [V1W-1:0]    v_q;
  logic [V2W-1:0]    w_q;
  logic [QW-1:0]     q_q;
  logic [V2W+RecipW-1:0] prod;
  logic [V2W-1:0]    rem_raw;
  logic [V2W-1:0]    rem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= in_key_i;
      line_q <= in_line_i;
      func_q <= in_func_i;
    end
    h_q <= key_q * 32'(HashMult) + {16'd0, line_q};
    v_q <= V1W'(h_q[31:16]) * V1W'(Pow16Mod) + V1W'(h_q[15:0]);
    w_q <= V2W'(v_q[V1W-1:16]) * V2W'(Pow16Mod) + V2W'(v_q[15:0]);
    q_q <= QW'(prod >> RecipShift);
  end

  assign prod    = (V2W + RecipW)'(w_q) * (V2W + RecipW)'(Recip);
  assign rem_raw = w_q - V2W'(q_q) * V2W'(TableSize);
  assign rem     = (rem_raw >= V2W'(TableSize)) ? rem_raw - V2W'(TableSize) : rem_raw;

  // probe position and counters
  logic [SlotW-1:0] idx_q;
  logic [CntW-1:0]  probe_q;
  logic [SlotW-1:0] clr_q;
  logic [CntW-1:0]  fill_q;
  logic [CntW-1:0]  len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) begin
      idx_q   <= SlotW'(rem);
      probe_q <= '0;
    end else if (cmd_i.next_probe) begin
      idx_q   <= (idx_q == SlotW'(TableSize - 1)) ? '0 : idx_q + 1'b1;
      probe_q <= probe_q + 1'b1;
    end
  end

  // slot memory
  row_t             row_mem [TableSize];
  row_t             rd_q;
  row_t             wr_row;
  logic             wr_en;
  logic [SlotW-1:0] wr_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= row_mem[idx_q];
    if (wr_en) row_mem[wr_addr] <= wr_row;
  end

  // slot update
  logic               hit;
  logic               drop;
  logic [31:0]        live_new;
  logic               raise;
  logic               first;
  row_t               upd_row;

  assign hit      = !rd_q.valid || (rd_q.key == key_q && rd_q.line == line_q);
  assign drop     = !hit || (!rd_q.valid && fill_q > CntW'(FillThr));
  assign live_new = func_q ? rd_q.live - 32'd1 : rd_q.live + 32'd1;
  assign raise    = ($signed(live_new) > limit_q) && ($signed(live_new) > $signed(rd_q.peak));
  assign first    = (rd_q.peak == 32'd0) && (len_q < CntW'(TableSize));

  always_comb begin
    upd_row       = rd_q;
    upd_row.valid = 1'b1;
    upd_row.key   = key_q;
    upd_row.line  = line_q;
    upd_row.live  = live_new;
    upd_row.peak  = raise ? live_new : rd_q.peak;
    upd_row.total = rd_q.total + 48'd1;
  end

  always_comb begin
    wr_en   = cmd_i.clr_wr || (cmd_i.commit && !drop);
    wr_addr = cmd_i.clr_wr ? clr_q : idx_q;
    wr_row  = cmd_i.clr_wr ? row_t'('0) : upd_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit && !drop) begin
        if (!rd_q.valid) fill_q <= fill_q + 1'b1;
        if (raise && first) len_q <= len_q + 1'b1;
      end
    end
  end

  // result register
  logic               out_valid_q;
  logic [1:0]         res_status_q;
  logic [9:0]         res_slot_q;
  logic signed [31:0] res_live_q;
  logic               res_new_leak_q;
  logic               res_raised_q;
  logic [9:0]         res_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.emit_off) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_off || (cmd_i.commit && drop)) begin
      res_status_q   <= cmd_i.emit_off ? StatDisabled : StatDropped;
      res_slot_q     <= '0;
      res_live_q     <= '0;
      res_new_leak_q <= 1'b0;
      res_raised_q   <= 1'b0;
      res_pos_q      <= '0;
    end else if (cmd_i.commit) begin
      res_status_q   <= StatCounted;
      res_slot_q     <= 10'(idx_q);
      res_live_q     <= $signed(live_new);
      res_new_leak_q <= raise && first;
      res_raised_q   <= raise;
      res_pos_q      <= (raise && first) ? 10'(len_q) : 10'd0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = res_status_q;
  assign out_slot_o          = res_slot_q;
  assign out_live_count_o    = res_live_q;
  assign out_new_leak_o      = res_new_leak_q;
  assign out_peak_raised_o   = res_raised_q;
  assign out_leak_position_o = res_pos_q;

  always_comb begin
    stat_o.clr_last   = clr_q == SlotW'(TableSize - 1);
    stat_o.enabled    = debug_q && (section_q != 10'd0);
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.hit        = hit;
    stat_o.probe_last = probe_q == CntW'(TableSize - 1);
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(FillThr + 1))
    else $error("fill count beyond insertion bound");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + 1'b1))
    else $error("fill count moved by more than one");
  a_leak_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_new_leak_q) |-> (res_raised_q && res_status_q == StatCounted))
    else $error("new leak without raised peak");
`endif

endmodule

FILE: hw/rtl/site_counter_hash_table_unit.sv
// Top level of the site counter hash table: channels, controller, datapath.
// Depends on sctbl_pkg, sctbl_if, sctbl_ctrl and sctbl_dp.
//
// Each item names an allocation site (site_key, site_line) and whether it
// allocates (func 0) or releases (func 1); each item yields exactly one result
// item. After reset the block sweeps its 997-slot table, one slot per cycle,
// so input ready stays low until the sweep ends (config writes are taken
// during the sweep). With counting disabled (debug_enable 0 or section_count
// 0) an item loads the result register at its accepting edge, so the result
// shows in the next cycle. Otherwise the site is hashed and reduced modulo
// the table size through h_q, v_q, w_q and q_q, then the single-port slot
// memory is probed linearly (registered read, then compare and write back)
// until a slot matches the site or is empty, or every slot has been probed;
// the result register loads after any wait for a previous result to be taken,
// and the next item can be accepted in the cycle after it loads. The result
// register frees the controller while a result waits to be taken; the block
// works on one item at a time. Config writes are always ready and must be
// issued only while the block is idle.
module site_counter_hash_table_unit import sctbl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  sctbl_in_if.sink   in_ch,
  sctbl_out_if.source out_ch,
  sctbl_cfg_if.sink  cfg_ch
);

  cmd_t  cmd;
  stat_t stat;

  // config registers take a write in any cycle
  assign cfg_ch.ready = 1'b1;

  sctbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sctbl_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_key_i            (in_ch.site_key),
    .in_line_i           (in_ch.site_line),
    .in_func_i           (in_ch.func),
    .cfg_valid_i         (cfg_ch.valid),
    .cfg_index_i         (cfg_ch.index),
    .cfg_data_i          (cfg_ch.data),
    .out_ready_i         (out_ch.ready),
    .out_valid_o         (out_ch.valid),
    .out_status_o        (out_ch.status),
    .out_slot_o          (out_ch.slot),
    .out_live_count_o    (out_ch.live_count),
    .out_new_leak_o      (out_ch.new_leak),
    .out_peak_raised_o   (out_ch.peak_raised),
    .out_leak_position_o (out_ch.leak_position),
    .cmd_i               (cmd),
    .stat_o              (stat)
  );

endmodule

FILE: tb/site_counter_hash_table_unit_test.sv
// Self-checking testbench for the site counter hash table unit.
// Depends on sctbl_pkg, the sctbl channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module site_counter_hash_table_unit_test;
  import sctbl_pkg::*;

  localparam int NumSlots = 997;

  // One expected result item.
  typedef struct {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] live;
    logic        new_leak;
    logic        raised;
    logic [9:0]  leak_pos;
  } site_result_t;

  typedef enum logic {RowCfg, RowSite} row_kind_e;

  // Directed stimulus row. Config rows reuse key as register index and
  // line as write data.
  typedef struct {
    row_kind_e   kind;
    logic [31:0] key;
    logic [15:0] line;
    logic        func;
    logic        typed;
    logic [1:0]  exp_status;
    int          exp_live;
  } site_row_t;

  localparam logic FuncAlloc   = 1'b0;
  localparam logic FuncRelease = 1'b1;

  logic clk;
  logic rst_n;

  sctbl_in_if  in_ch ();
  sctbl_out_if out_ch ();
  sctbl_cfg_if cfg_ch ();

  site_counter_hash_table_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Mirror of the block's table and registers.
  bit          mir_valid [NumSlots];
  bit [31:0]   mir_key   [NumSlots];
  bit [15:0]   mir_line  [NumSlots];
  bit [31:0]   mir_live  [NumSlots];
  bit [31:0]   mir_peak  [NumSlots];
  bit [47:0]   mir_total [NumSlots];
  int          mir_fill;
  int          mir_leak_len;
  bit          reg_debug;
  bit [9:0]    reg_sections;
  bit [15:0]   reg_clients;

  site_result_t pending_results[$];
  int           mismatch_cnt;
  int           result_cnt;
  int           leak_cnt;
  int           drop_cnt;
  int           snd_idle;
  int           rcv_idle;

  // Directed table: disabled cases first, then collisions, wrap below zero
  // and the register extremes.
  site_row_t site_rows[] = '{
    '{RowSite, 32'h0, 16'h0, FuncAlloc, 1'b1, StatDisabled, 0},
    '{RowSite, 32'hFFFF_FFFF, 16'hFFFF, FuncRelease, 1'b1, StatDisabled, 0},
    '{RowCfg, 32'(CfgDebugEnable), 16'd1, FuncAlloc, 1'b0, StatCounted, 0},
    '{RowSite, 32'h1, 16'h2, FuncAlloc, 1'b1, StatDisabled, 0},
    '{RowCfg, 32'(CfgSectionCount), 16'd1, FuncAlloc, 1'b0, StatCounted, 0},
    '{RowSite, 32'h0, 16'h0, FuncAlloc, 1'b1, StatCounted, 1},
    '{RowSite, 32'h0, 16'h0, FuncAlloc, 1'b1, StatCounted, 2},
    '{RowSite, 32'h0, 16'h0, FuncRelease, 1'b1, StatCounted, 1},
    '{RowSite, 32'h0, 16'd997, FuncAlloc, 1'b1, StatCounted, 1},
    '{RowSite, 32'h0, 16'd1994, FuncAlloc, 1'b1, StatCounted, 1},
    '{RowSite, 32'hFFFF_FFFF, 16'hFFFF, FuncAlloc, 1'b1, StatCounted, 1},
    '{RowSite, 32'hFFFF_FFFF, 16'hFFFF, FuncRelease, 1'b1, StatCounted, 0},
    '{RowSite, 32'hFFFF_FFFF, 16'hFFFF, FuncRelease, 1'b1, StatCounted, -1},
    '{RowSite, 32'hFFFF_FFFF, 16'hFFFF, FuncRelease, 1'b1, StatCounted, -2},
    '{RowCfg, 32'(CfgClientCount), 16'hFFFF, FuncAlloc, 1'b0, StatCounted, 0},
    '{RowSite, 32'h0, 16'h0, FuncRelease, 1'b1, StatCounted, 0},
    '{RowSite, 32'h0, 16'd997, FuncRelease, 1'b1, StatCounted, 0},
    '{RowCfg, 32'(CfgSectionCount), 16'd1023, FuncAlloc, 1'b0, StatCounted, 0},
    '{RowSite, 32'h5, 16'h0, FuncAlloc, 1'b1, StatCounted, 1},
    '{RowSite, 32'h8000_0000, 16'h8000, FuncAlloc, 1'b0, StatCounted, 0}
  };

  // Pool of recurring sites so random items hit existing slots.
  logic [31:0] pool_key [48];
  logic [15:0] pool_line[48];

  // Free-running clock.
  always #5 clk = ~clk;

  // Hash, probe and update the mirror for one accepted item.
  function automatic site_result_t count_site(logic [31:0] key, logic [15:0] line,
                                              logic func);
    site_result_t res;
    bit [31:0]    hash;
    int           idx;
    int           n;
    bit           found;
    int           live;
    int           peak;
    int           limit;
    res = '{StatCounted, 10'd0, 32'd0, 1'b0, 1'b0, 10'd0};
    found = 1'b0;
    if (!reg_debug || reg_sections == 0) begin
      res.status = StatDisabled;
      return res;
    end
    hash = 32'd1777 * key + {16'd0, line};
    idx = int'(hash % 32'd997);
    for (n = 0; n < NumSlots; n++) begin
      if (!mir_valid[idx] || (mir_key[idx] == key && mir_line[idx] == line)) begin
        found = 1'b1;
        break;
      end
      idx = (idx + 1) % NumSlots;
    end
    if (!found) begin
      res.status = StatDropped;
      return res;
    end
    if (!mir_valid[idx]) begin
      // Insert only while the fill count leaves the margin.
      if (mir_fill > NumSlots - 100) begin
        res.status = StatDropped;
        return res;
      end
      mir_fill++;
      mir_valid[idx] = 1'b1;
      mir_key[idx]   = key;
      mir_line[idx]  = line;
    end
    mir_total[idx] = mir_total[idx] + 48'd1;
    mir_live[idx]  = func ? mir_live[idx] - 32'd1 : mir_live[idx] + 32'd1;
    live  = signed'(mir_live[idx]);
    peak  = signed'(mir_peak[idx]);
    limit = 10000 * (int'(reg_sections) + 1) + 100 * int'(reg_clients);
    if (live > limit && live > peak) begin
      res.raised = 1'b1;
      if (peak == 0 && mir_leak_len < NumSlots) begin
        res.new_leak = 1'b1;
        res.leak_pos = 10'(mir_leak_len);
        mir_leak_len++;
      end
      mir_peak[idx] = mir_live[idx];
    end
    res.slot = 10'(idx);
    res.live = mir_live[idx];
    return res;
  endfunction

  function automatic void note_mismatch(string what, longint exp_v, longint act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
  endfunction

  // Offer one item; hold valid high afterwards so back-to-back items never
  // lower and raise it in the same step.
  task automatic send_site(logic [31:0] key, logic [15:0] line, logic func,
                           output site_result_t res);
    int gap;
    if ($urandom_range(99) < snd_idle) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    in_ch.site_key  = key;
    in_ch.site_line = line;
    in_ch.func      = func;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    res = count_site(key, line, func);
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    cfg_ch.index = index;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CfgDebugEnable:  reg_debug    = data[0];
      CfgSectionCount: reg_sections = data[9:0];
      CfgClientCount:  reg_clients  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic setup(logic dbg, logic [9:0] sec, logic [15:0] cli);
    drain();
    write_reg(CfgDebugEnable, {15'd0, dbg});
    write_reg(CfgSectionCount, {6'd0, sec});
    write_reg(CfgClientCount, cli);
  endtask

  // Mostly recurring sites with random direction, some fresh sites.
  task automatic random_sites(int count);
    site_result_t res;
    int           pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(47);
      if ($urandom_range(99) < 75)
        send_site(pool_key[pick], pool_line[pick], 1'($urandom_range(99) < 40), res);
      else
        send_site($urandom, 16'($urandom), 1'($urandom), res);
    end
  endtask

  // Receiver: stall at random, check each result against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    site_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", -1, out_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (want.new_leak) leak_cnt++;
        if (want.status == StatDropped) drop_cnt++;
        if (out_ch.status !== want.status)
          note_mismatch("status", want.status, out_ch.status);
        if (out_ch.slot !== want.slot)
          note_mismatch("slot", want.slot, out_ch.slot);
        if (out_ch.live_count !== want.live)
          note_mismatch("live_count", signed'(want.live), out_ch.live_count);
        if (out_ch.new_leak !== want.new_leak)
          note_mismatch("new_leak", want.new_leak, out_ch.new_leak);
        if (out_ch.peak_raised !== want.raised)
          note_mismatch("peak_raised", want.raised, out_ch.peak_raised);
        if (out_ch.leak_position !== want.leak_pos)
          note_mismatch("leak_position", want.leak_pos, out_ch.leak_position);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    site_result_t res;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.site_key = '0;
    in_ch.site_line = '0;
    in_ch.func = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    snd_idle = 0;
    rcv_idle = 0;
    mismatch_cnt = 0;
    result_cnt = 0;
    leak_cnt = 0;
    drop_cnt = 0;
    mir_fill = 0;
    mir_leak_len = 0;
    reg_debug = 1'b0;
    reg_sections = '0;
    reg_clients = '0;
    for (int i = 0; i < NumSlots; i++) begin
      mir_valid[i] = 1'b0;
      mir_live[i] = '0;
      mir_peak[i] = '0;
      mir_total[i] = '0;
    end
    for (int i = 0; i < 48; i++) begin
      pool_key[i]  = (i < 4) ? ((i % 2) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
      pool_line[i] = (i % 8 == 0) ? 16'h0 : 16'($urandom);
    end

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table; typed rows also check the mirror itself.
    foreach (site_rows[r]) begin
      if (site_rows[r].kind == RowCfg) begin
        drain();
        write_reg(site_rows[r].key[CfgIdxW-1:0], site_rows[r].line);
      end else begin
        send_site(site_rows[r].key, site_rows[r].line, site_rows[r].func, res);
        if (site_rows[r].typed && (res.status !== site_rows[r].exp_status ||
            signed'(res.live) != site_rows[r].exp_live))
          note_mismatch("directed row live", site_rows[r].exp_live, signed'(res.live));
      end
    end

    // Random phases: sender idles less than receiver, then the reverse,
    // then no idling at all, each under different register settings.
    snd_idle = 23; rcv_idle = 67;
    setup(1'b1, 10'd1023, 16'hFFFF);
    random_sites(150);
    // Pause the sender until everything is back, then continue.
    drain();
    random_sites(150);
    setup(1'b0, 10'd7, 16'd3);
    random_sites(40);
    snd_idle = 67; rcv_idle = 23;
    setup(1'b1, 10'd5, 16'd0);
    random_sites(320);
    snd_idle = 0; rcv_idle = 0;
    setup(1'b1, 10'd0, 16'd12);
    random_sites(20);
    setup(1'b1, 10'd2, 16'd1000);
    random_sites(330);

    // Fill the table past its margin with fresh sites, then mix in old ones.
    snd_idle = 23; rcv_idle = 23;
    setup(1'b1, 10'd3, 16'd50);
    for (int i = 0; i < 920; i++) send_site($urandom, 16'($urandom), 1'($urandom), res);
    random_sites(60);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d results, %0d new leaks, %0d dropped items.",
             result_cnt, leak_cnt, drop_cnt);
    $display("Table fill reached %0d slots; %0d mismatches.", mir_fill, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: site_counter_hash_table_unit.f
hw/rtl/sctbl_pkg.sv
hw/rtl/sctbl_if.sv
hw/rtl/sctbl_ctrl.sv
hw/rtl/sctbl_dp.sv
hw/rtl/site_counter_hash_table_unit.sv
tb/site_counter_hash_table_unit_test.sv
